>>> hdl/qeb_pkg.sv
// ----------------------------------------------------------------------------
// qeb_pkg
// Shared widths, constants, types and the arctangent table of the
// quaternion to Euler angle bin converter.
// ----------------------------------------------------------------------------
package qeb_pkg;

  localparam int QW       = 16;
  localparam int PROD_W   = 32;
  localparam int ARG_W    = 34;
  localparam int S_W      = 32;
  localparam int SQ_W     = 61;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 31;
  localparam int RT_W     = 32;
  localparam int REM_W    = 35;
  localparam int CW       = 36;
  localparam int ANG_W    = 18;
  localparam int STEPS    = 15;
  localparam int LANES    = 3;
  localparam int BIN_W    = 5;
  localparam int BINS_W   = 8;
  localparam int BINS_DEF = 18;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(32768);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(16384);

  typedef struct packed {
    logic signed [ARG_W-1:0] rn;
    logic signed [ARG_W-1:0] rd;
    logic signed [ARG_W-1:0] yn;
    logic signed [ARG_W-1:0] yd;
    logic signed [S_W-1:0]   s;
  } qeb_args_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      4'd0:    r = ANG_W'(8192);
      4'd1:    r = ANG_W'(4836);
      4'd2:    r = ANG_W'(2555);
      4'd3:    r = ANG_W'(1297);
      4'd4:    r = ANG_W'(651);
      4'd5:    r = ANG_W'(326);
      4'd6:    r = ANG_W'(163);
      4'd7:    r = ANG_W'(81);
      4'd8:    r = ANG_W'(41);
      4'd9:    r = ANG_W'(20);
      4'd10:   r = ANG_W'(10);
      4'd11:   r = ANG_W'(5);
      4'd12:   r = ANG_W'(3);
      4'd13:   r = ANG_W'(1);
      4'd14:   r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/qeb_front.sv
// ----------------------------------------------------------------------------
// qeb_front
// Three stages: component products, the atan2 operands with the saturated
// pitch sine, and the radicand of the pitch cosine.
// ----------------------------------------------------------------------------
module qeb_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [qeb_pkg::QW-1:0]        quat_w_i,
  input  logic signed [qeb_pkg::QW-1:0]        quat_x_i,
  input  logic signed [qeb_pkg::QW-1:0]        quat_y_i,
  input  logic signed [qeb_pkg::QW-1:0]        quat_z_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output qeb_pkg::qeb_args_t                   args_o,
  output logic [qeb_pkg::SQ_W-1:0]             rad_o
);

  localparam int NS    = 3;
  localparam int PW    = qeb_pkg::PROD_W;
  localparam int AW    = qeb_pkg::ARG_W;
  localparam int SW    = qeb_pkg::S_W;
  localparam int QW    = qeb_pkg::SQ_W;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  logic signed [PW-1:0] we, xe, ye, ze;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  qeb_pkg::qeb_args_t   args1_d, args1_q, args2_q;
  logic signed [AW-1:0] sfull;
  logic [SW-2:0]        smag;
  logic [2*SW-3:0]      sq;
  logic [2*SW-3:0]      rad_full;
  logic [QW-1:0]        rad_q;

  assign en[NS-1] = !vld_q[NS-1] || ready_i;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign we = PW'(quat_w_i);
  assign xe = PW'(quat_x_i);
  assign ye = PW'(quat_y_i);
  assign ze = PW'(quat_z_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      wx_q <= we * xe;
      yz_q <= ye * ze;
      xx_q <= xe * xe;
      yy_q <= ye * ye;
      wz_q <= we * ze;
      xy_q <= xe * ye;
      zz_q <= ze * ze;
      wy_q <= we * ye;
      zx_q <= ze * xe;
    end
  end

  always_comb begin
    args1_d.rn = (AW'(wx_q) + AW'(yz_q)) <<< 1;
    args1_d.rd = AW'(34'sd1073741824) - ((AW'(xx_q) + AW'(yy_q)) <<< 1);
    args1_d.yn = (AW'(wz_q) + AW'(xy_q)) <<< 1;
    args1_d.yd = AW'(34'sd1073741824) - ((AW'(yy_q) + AW'(zz_q)) <<< 1);
    sfull      = (AW'(wy_q) - AW'(zx_q)) <<< 1;
    if (sfull > AW'(34'sd1073741824)) begin
      args1_d.s = SW'(32'sd1073741824);
    end else if (sfull < -AW'(34'sd1073741824)) begin
      args1_d.s = -SW'(32'sd1073741824);
    end else begin
      args1_d.s = SW'(sfull);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) args1_q <= args1_d;
  end

  assign smag     = args1_q.s[SW-1] ? (SW-1)'(-args1_q.s) : (SW-1)'(args1_q.s);
  assign sq       = smag * smag;
  assign rad_full = (62'd1 << 60) - sq;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      args2_q <= args1_q;
      rad_q   <= rad_full[QW-1:0];
    end
  end

  assign args_o = args2_q;
  assign rad_o  = rad_q;

endmodule

>>> hdl/qeb_sqrt.sv
// ----------------------------------------------------------------------------
// qeb_sqrt
// Pipelined integer square root, two result digits per stage, that carries
// the atan2 operands alongside.
// ----------------------------------------------------------------------------
module qeb_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  qeb_pkg::qeb_args_t            args_i,
  input  logic [qeb_pkg::SQ_W-1:0]      rad_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output qeb_pkg::qeb_args_t            args_o,
  output logic [qeb_pkg::ROOT_W-1:0]    root_o
);

  localparam int DPS = 2;
  localparam int RW  = qeb_pkg::RAD_W;
  localparam int TW  = qeb_pkg::RT_W;
  localparam int MW  = qeb_pkg::REM_W;
  localparam int NS  = TW / DPS;

  logic [NS-1:0]      vld_q;
  logic [NS-1:0]      en;
  logic [RW-1:0]      rad_q  [NS];
  logic [MW-1:0]      rem_q  [NS];
  logic [TW-1:0]      rt_q   [NS];
  qeb_pkg::qeb_args_t args_q [NS];

  assign en[NS-1] = !vld_q[NS-1] || ready_i;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0]      rad_s, rad_d;
    logic [MW-1:0]      rem_s, rem_d;
    logic [TW-1:0]      rt_s, rt_d;
    qeb_pkg::qeb_args_t args_s;

    if (k == 0) begin : g_first
      assign rad_s  = RW'(rad_i);
      assign rem_s  = '0;
      assign rt_s   = '0;
      assign args_s = args_i;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign rt_s   = rt_q[k-1];
      assign args_s = args_q[k-1];
    end

    always_comb begin
      logic [MW-1:0] trial;
      rad_d = rad_s;
      rem_d = rem_s;
      rt_d  = rt_s;
      for (int d = 0; d < DPS; d++) begin
        rem_d = {rem_d[MW-3:0], rad_d[RW-1 -: 2]};
        rad_d = rad_d << 2;
        trial = {1'b0, rt_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d = rem_d - trial;
          rt_d  = {rt_d[TW-2:0], 1'b1};
        end else begin
          rt_d  = {rt_d[TW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        rt_q[k]   <= rt_d;
        args_q[k] <= args_s;
      end
    end
  end

  assign args_o = args_q[NS-1];
  assign root_o = rt_q[NS-1][qeb_pkg::ROOT_W-1:0];

endmodule

>>> hdl/qeb_cordic.sv
// ----------------------------------------------------------------------------
// qeb_cordic
// Three-lane vectoring CORDIC: a quadrant and special-case stage, then one
// micro-rotation per stage for roll, pitch and yaw side by side.
// ----------------------------------------------------------------------------
module qeb_cordic (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  qeb_pkg::qeb_args_t                       args_i,
  input  logic [qeb_pkg::ROOT_W-1:0]               root_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic signed [qeb_pkg::ANG_W-1:0]         ang_o [qeb_pkg::LANES]
);

  localparam int CW = qeb_pkg::CW;
  localparam int AW = qeb_pkg::ANG_W;
  localparam int NL = qeb_pkg::LANES;
  localparam int NS = qeb_pkg::STEPS + 1;

  logic [NS-1:0]        vld_q;
  logic [NS-1:0]        en;
  logic signed [CW-1:0] x_q   [NS][NL];
  logic signed [CW-1:0] y_q   [NS][NL];
  logic signed [AW-1:0] acc_q [NS][NL];
  logic signed [CW-1:0] num   [NL];
  logic signed [CW-1:0] den   [NL];

  assign en[NS-1] = !vld_q[NS-1] || ready_i;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign num[qeb_pkg::LANE_ROLL]  = CW'($signed(args_i.rn));
  assign den[qeb_pkg::LANE_ROLL]  = CW'($signed(args_i.rd));
  assign num[qeb_pkg::LANE_PITCH] = CW'($signed(args_i.s));
  assign den[qeb_pkg::LANE_PITCH] = {{(CW-qeb_pkg::ROOT_W){1'b0}}, root_i};
  assign num[qeb_pkg::LANE_YAW]   = CW'($signed(args_i.yn));
  assign den[qeb_pkg::LANE_YAW]   = CW'($signed(args_i.yd));

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic signed [CW-1:0] x0, y0;
    logic signed [AW-1:0] a0;

    // A vector on an axis gets its exact angle and a zero y, which
    // freezes it through all micro-rotations.
    always_comb begin
      x0 = den[l];
      y0 = num[l];
      a0 = '0;
      if (num[l] == '0) begin
        y0 = '0;
        a0 = (den[l] < 0) ? qeb_pkg::HALF_TURN : '0;
      end else if (den[l] == '0) begin
        y0 = '0;
        a0 = (num[l] > 0) ? qeb_pkg::QUARTER_TURN : -qeb_pkg::QUARTER_TURN;
      end else if (den[l] < 0) begin
        if (num[l] >= 0) begin
          x0 = num[l];
          y0 = -den[l];
          a0 = qeb_pkg::QUARTER_TURN;
        end else begin
          x0 = -num[l];
          y0 = den[l];
          a0 = -qeb_pkg::QUARTER_TURN;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[0]) begin
        x_q[0][l]   <= x0;
        y_q[0][l]   <= y0;
        acc_q[0][l] <= a0;
      end
    end

    for (genvar k = 0; k < NS-1; k++) begin : g_step
      logic signed [CW-1:0] xs, ys, x_d, y_d;
      logic signed [AW-1:0] a_d;

      assign xs = x_q[k][l] >>> k;
      assign ys = y_q[k][l] >>> k;

      always_comb begin
        x_d = x_q[k][l];
        y_d = y_q[k][l];
        a_d = acc_q[k][l];
        if (y_q[k][l] > 0) begin
          x_d = x_q[k][l] + ys;
          y_d = y_q[k][l] - xs;
          a_d = acc_q[k][l] + qeb_pkg::atan_lut(4'(k));
        end else if (y_q[k][l] < 0) begin
          x_d = x_q[k][l] - ys;
          y_d = y_q[k][l] + xs;
          a_d = acc_q[k][l] - qeb_pkg::atan_lut(4'(k));
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[k+1]) begin
          x_q[k+1][l]   <= x_d;
          y_q[k+1][l]   <= y_d;
          acc_q[k+1][l] <= a_d;
        end
      end
    end

    assign ang_o[l] = acc_q[NS-1][l];
  end

endmodule

>>> hdl/qeb_bin.sv
// ----------------------------------------------------------------------------
// qeb_bin
// Output register: saturates the three angles and scales them onto bins.
// ----------------------------------------------------------------------------
module qeb_bin #(
  parameter int BINS = qeb_pkg::BINS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [qeb_pkg::ANG_W-1:0]     ang_i [qeb_pkg::LANES],
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [qeb_pkg::BIN_W-1:0]            roll_bin_o,
  output logic [qeb_pkg::BIN_W-1:0]            pitch_bin_o,
  output logic [qeb_pkg::BIN_W-1:0]            yaw_bin_o
);

  localparam int AW = qeb_pkg::ANG_W;
  localparam int UW = 17;
  localparam int MW = UW + qeb_pkg::BINS_W;
  localparam int BW = qeb_pkg::BIN_W;

  logic                           vld_q;
  logic                           en;
  logic [qeb_pkg::BINS_W-1:0]     bins_c;
  logic signed [AW-1:0]           rs, ps, ys;
  logic [UW-1:0]                  ru, pu, yu;
  logic [MW-1:0]                  rm, pm, ym;
  logic [BW-1:0]                  roll_q, pitch_q, yaw_q;

  assign bins_c  = qeb_pkg::BINS_W'(BINS);
  assign en      = !vld_q || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q;

  function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] a,
                                               input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    r = a;
    if (a > lim) r = lim;
    if (a < -lim) r = -lim;
    return r;
  endfunction

  assign rs = sat(ang_i[qeb_pkg::LANE_ROLL], qeb_pkg::HALF_TURN);
  assign ps = sat(ang_i[qeb_pkg::LANE_PITCH], qeb_pkg::QUARTER_TURN);
  assign ys = sat(ang_i[qeb_pkg::LANE_YAW], qeb_pkg::HALF_TURN);

  assign ru = UW'(rs + qeb_pkg::HALF_TURN);
  assign pu = UW'(ps + qeb_pkg::QUARTER_TURN);
  assign yu = UW'(ys + qeb_pkg::HALF_TURN);

  assign rm = ru * bins_c;
  assign pm = pu * bins_c;
  assign ym = yu * bins_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= rm[16 +: BW];
      pitch_q <= pm[15 +: BW];
      yaw_q   <= ym[16 +: BW];
    end
  end

  assign roll_bin_o  = roll_q;
  assign pitch_bin_o = pitch_q;
  assign yaw_bin_o   = yaw_q;

endmodule

>>> hdl/quaternion_to_euler_bins_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins_core
// Converts an orientation quaternion into roll, pitch and yaw bins.
// ----------------------------------------------------------------------------
// The slave stream takes one quaternion per request in s_axis_tdata, four
// signed Q1.15 components. The master stream returns one request per input
// with the roll, pitch and yaw bins in m_axis_tdata, in the same order.
// From acceptance to m_axis_tvalid a request passes three front stages for
// products and operands, sixteen square-root stages of two digits each, one
// quadrant stage and fifteen CORDIC micro-rotation stages, and the bin output
// register. Throughput is one request per clock unless the receiver stalls;
// every stage holds a valid bit and loads whenever it is empty or its
// successor moves. When the receiver stalls, the pipeline fills up behind
// the output register and s_axis_tready falls only once every stage holds
// a request; nothing is dropped or repeated. Reset clears all valid bits,
// so both streams come up idle and s_axis_tready high.
// ----------------------------------------------------------------------------
module quaternion_to_euler_bins_core #(
  parameter int BINS = qeb_pkg::BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // roll_bin, pitch_bin, yaw_bin, zero pad
);

  localparam int BW = qeb_pkg::BIN_W;

  logic                               fr_valid, fr_ready;
  qeb_pkg::qeb_args_t                 fr_args;
  logic [qeb_pkg::SQ_W-1:0]           fr_rad;
  logic                               sq_valid, sq_ready;
  qeb_pkg::qeb_args_t                 sq_args;
  logic [qeb_pkg::ROOT_W-1:0]         sq_root;
  logic                               co_valid, co_ready;
  logic signed [qeb_pkg::ANG_W-1:0]   co_ang [qeb_pkg::LANES];
  logic [BW-1:0]                      roll_bin, pitch_bin, yaw_bin;

  qeb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .quat_w_i ($signed(s_axis_tdata[15:0])),
    .quat_x_i ($signed(s_axis_tdata[31:16])),
    .quat_y_i ($signed(s_axis_tdata[47:32])),
    .quat_z_i ($signed(s_axis_tdata[63:48])),
    .valid_o  (fr_valid),
    .ready_i  (fr_ready),
    .args_o   (fr_args),
    .rad_o    (fr_rad)
  );

  qeb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .args_i  (fr_args),
    .rad_i   (fr_rad),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .args_o  (sq_args),
    .root_o  (sq_root)
  );

  qeb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .args_i  (sq_args),
    .root_i  (sq_root),
    .valid_o (co_valid),
    .ready_i (co_ready),
    .ang_o   (co_ang)
  );

  qeb_bin #(
    .BINS (BINS)
  ) u_bin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (co_valid),
    .ready_o     (co_ready),
    .ang_i       (co_ang),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .roll_bin_o  (roll_bin),
    .pitch_bin_o (pitch_bin),
    .yaw_bin_o   (yaw_bin)
  );

  assign m_axis_tdata = {1'b0, yaw_bin, pitch_bin, roll_bin};

  // A receiver that takes every request never throttles the sender.
  a_ready_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (BINS > 31) || (32'(roll_bin) <= 32'(BINS)))
    else $error("roll bin out of range");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (BINS > 31) || (32'(pitch_bin) <= 32'(BINS)))
    else $error("pitch bin out of range");

  a_yaw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (BINS > 31) || (32'(yaw_bin) <= 32'(BINS)))
    else $error("yaw bin out of range");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion to Euler angle bin converter. A
// fixed-point model predicts roll, pitch and yaw bins for every accepted
// quaternion; each output request is compared in order against the queue of
// predicted bins while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [qeb_pkg::BIN_W-1:0] yaw;
    logic [qeb_pkg::BIN_W-1:0] pitch;
    logic [qeb_pkg::BIN_W-1:0] roll;
  } bins_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // roll_bin, pitch_bin, yaw_bin, zero pad

  bins_t bins_q[$];
  int    n_err = 0;
  int    n_sent = 0;
  int    n_recv = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;
  bit    hold_off = 1'b0;
  bit    no_stall = 1'b0;

  always #4 clk_i = ~clk_i;

  quaternion_to_euler_bins_core u_top (.*);

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint num, longint den);
    longint x, y, acc, nx;
    longint lut[qeb_pkg::STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
                                    20, 10, 5, 3, 1, 1};
    if (num == 0) return (den < 0) ? 32768 : 0;
    if (den == 0) return (num > 0) ? 16384 : -16384;
    x = den;
    y = num;
    acc = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; x = nx; acc = 16384;
      end else begin
        nx = -y; y = x; x = nx; acc = -16384;
      end
    end
    for (int i = 0; i < qeb_pkg::STEPS; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        acc += lut[i];
      end else begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        acc -= lut[i];
      end
      x = nx;
    end
    if (acc > 32768) acc = 32768;
    if (acc < -32768) acc = -32768;
    return acc;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic bins_t predict_bins(logic [63:0] q);
    longint w, x, y, z, s, c, rl, yw, pt;
    longint one = 64'sd1 << 30;
    bins_t b;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    rl = cordic_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    yw = cordic_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = int_sqrt((64'd1 << 60) - longint'(s * s));
    pt = cordic_angle(s, c);
    if (pt > 16384) pt = 16384;
    if (pt < -16384) pt = -16384;
    b.roll  = qeb_pkg::BIN_W'(((rl + 32768) * qeb_pkg::BINS_DEF) >>> 16);
    b.pitch = qeb_pkg::BIN_W'(((pt + 16384) * qeb_pkg::BINS_DEF) >>> 15);
    b.yaw   = qeb_pkg::BIN_W'(((yw + 32768) * qeb_pkg::BINS_DEF) >>> 16);
    return b;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  task automatic send_quat(logic [15:0] w, x, y, z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x, w};
    do @(posedge clk_i); while (!s_axis_tready);
    bins_q.push_back(predict_bins({z, y, x, w}));
    n_sent++;
    burst_left--;
  endtask

  task automatic finish_send();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (no_stall) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk_i) begin
    bins_t got, exp_b;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[14:0];
      n_recv++;
      if (bins_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_err++;
      end else begin
        exp_b = bins_q.pop_front();
        if (got.roll !== exp_b.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, exp_b.roll, got.roll);
          n_err++;
        end
        if (got.pitch !== exp_b.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, exp_b.pitch, got.pitch);
          n_err++;
        end
        if (got.yaw !== exp_b.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, exp_b.yaw, got.yaw);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_corners();
    logic [15:0] e[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000};
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);  // identity
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero over positive
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);  // roll at plus pi
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);  // yaw at plus pi
    send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);  // pitch near a quarter turn
    send_quat(16'h5A82, 16'h0000, 16'hA57E, 16'h0000);  // pitch near minus a quarter
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // non-unit, saturated
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000);  // tiny roll denominator
    send_quat(16'h5A82, 16'h0000, 16'h0000, 16'hA57E);  // tiny yaw denominator
    for (int i = 0; i < 14; i++)
      send_quat(e[$urandom_range(0, 5)], e[$urandom_range(0, 5)],
                e[$urandom_range(0, 5)], e[$urandom_range(0, 5)]);
  endtask

  task automatic test_random(int n);
    logic [15:0] c[4];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: c[k] = 16'($urandom());
          1: c[k] = $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 64))
                                          : 16'(16'h8000 + $urandom_range(0, 64));
          2: c[k] = 16'($signed($urandom_range(0, 2000)) - 1000);
          default: c[k] = 16'($signed($urandom_range(0, 46340)) - 23170);
        endcase
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(100);
    join
  endtask

  task automatic test_streaming();
    no_stall = 1'b1;
    for (int i = 0; i < 150; i++) begin
      burst_left = 200;
      send_quat(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random(350);
    test_backpressure();
    test_streaming();
    test_random(230);
    finish_send();
    while (bins_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d quaternions and checked %0d bin results,", n_sent, n_recv);
    $display("including corner values, long stalls and full-rate streaming.");
    if (n_err == 0 && bins_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
